>>> rtl/tbd_pkg.sv
// Shared types, constants and helpers for the Thumb block decoder.
`default_nettype none
package tbd_pkg;

	// Block limits.
	localparam int MaxBlockInsns = 32;
	localparam int MaxOps        = 64;

	// Counter widths follow from the limits.
	localparam int InsnCntW = $clog2(MaxBlockInsns + 1);
	localparam int OpCntW   = $clog2(MaxOps + 1);

	localparam logic [InsnCntW-1:0] InsnLimit = InsnCntW'(MaxBlockInsns);
	localparam logic [OpCntW-1:0]   OpLimit   = OpCntW'(MaxOps - 1);

	// Input item kinds.
	localparam logic KindStart = 1'b0;
	localparam logic KindInsn  = 1'b1;

	// Marker in the second source field for the immediate operand form.
	localparam logic [7:0] ImmOperand = 8'hFF;

	typedef enum logic [3:0] {
		OP_MOVSHIFT = 4'd0,
		OP_ADDREG   = 4'd1,
		OP_SUBREG   = 4'd2,
		OP_MOVIMM   = 4'd3,
		OP_CMPIMM   = 4'd4,
		OP_ADDIMM   = 4'd5,
		OP_SUBIMM   = 4'd6,
		OP_ALU      = 4'd7,
		OP_BRANCH   = 4'd8,
		OP_EXIT     = 4'd9
	} op_kind_t;

	typedef struct packed {
		op_kind_t    op_kind;
		logic [2:0]  dest_reg;
		logic [2:0]  first_src_reg;
		logic [7:0]  second_src_reg;
		logic [3:0]  op_variant;
		logic [31:0] immediate;
		logic        block_empty;
		logic        last;
	} res_t;

	// Exit op that closes a block.
	function automatic res_t exit_res(input logic empty);
		res_t r;
		r                = '0;
		r.op_kind        = OP_EXIT;
		r.block_empty    = empty;
		r.last           = 1'b1;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/tbd_if.sv
// Valid/ready channel interfaces for fetched halfwords and decoded ops.
`default_nettype none
interface tbd_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] start_address;
	logic [15:0] insn;

	modport source(output valid, kind, start_address, insn, input ready);
	modport sink(input valid, kind, start_address, insn, output ready);
endinterface

interface tbd_out_if;
	import tbd_pkg::*;
	logic        valid;
	logic        ready;
	op_kind_t    op_kind;
	logic [2:0]  dest_reg;
	logic [2:0]  first_src_reg;
	logic [7:0]  second_src_reg;
	logic [3:0]  op_variant;
	logic [31:0] immediate;
	logic        block_empty;
	logic        last;

	modport source(output valid, op_kind, dest_reg, first_src_reg, second_src_reg,
		op_variant, immediate, block_empty, last, input ready);
	modport sink(input valid, op_kind, dest_reg, first_src_reg, second_src_reg,
		op_variant, immediate, block_empty, last, output ready);
endinterface
`default_nettype wire

>>> rtl/tbd_decode.sv
// Combinational decode of one Thumb halfword into an op.
`default_nettype none
module tbd_decode (
	input  logic [15:0]   insn,
	input  logic [31:0]   pc,
	output tbd_pkg::res_t res,
	output logic          supported
);
	import tbd_pkg::*;

	logic [31:0] br_off;

	// Doubled, sign-extended 11-bit offset.
	assign br_off = {{21{insn[10]}}, insn[9:0], 1'b0};

	always_comb begin
		res       = '0;
		supported = 1'b1;
		if (insn[15:13] == 3'b000 && insn[12:11] != 2'b11) begin
			res.op_kind        = OP_MOVSHIFT;
			res.dest_reg       = insn[2:0];
			res.second_src_reg = {5'd0, insn[5:3]};
			res.op_variant     = {2'd0, insn[12:11]};
			res.immediate      = {27'd0, insn[10:6]};
		end else if (insn[15:11] == 5'b00011) begin
			res.op_kind       = insn[9] ? OP_SUBREG : OP_ADDREG;
			res.dest_reg      = insn[2:0];
			res.first_src_reg = insn[5:3];
			if (insn[10]) begin
				res.second_src_reg = ImmOperand;
				res.immediate      = {29'd0, insn[8:6]};
			end else begin
				res.second_src_reg = {5'd0, insn[8:6]};
			end
		end else if (insn[15:13] == 3'b001) begin
			res.op_kind   = op_kind_t'(4'(OP_MOVIMM) + {2'd0, insn[12:11]});
			res.dest_reg  = insn[10:8];
			res.immediate = {24'd0, insn[7:0]};
		end else if (insn[15:10] == 6'b010000) begin
			res.op_kind        = OP_ALU;
			res.dest_reg       = insn[2:0];
			res.second_src_reg = {5'd0, insn[5:3]};
			res.op_variant     = insn[9:6];
		end else if (insn[15:11] == 5'b11100) begin
			res.op_kind   = OP_BRANCH;
			res.immediate = (pc + 32'd4 + br_off) & 32'hFFFF_FFFE;
		end else begin
			supported = 1'b0;
		end
	end

endmodule
`default_nettype wire

>>> rtl/thumb_block_decoder_core.sv
// Top level of the Thumb block decoder: block state, decode stage and result register.
// An accepted item is registered in the input stage and decoded there, and its first
// result is then registered in the result register that drives the output.
// Throughput: one item per cycle while the output is not stalled; a non-branch
// item at a block limit emits two results and holds decode while the exit op goes out.
// Reset: arst_n clears all control state; no block is open after reset.
`default_nettype none
module thumb_block_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	tbd_in_if.sink     fetch,
	tbd_out_if.source  ops
);
	import tbd_pkg::*;

	// Input stage register.
	logic        s1_valid;
	logic        kind_s1;
	logic [31:0] start_address_s1;
	logic [15:0] insn_s1;

	// Block state.
	logic [31:0]         cursor_q;
	logic [OpCntW-1:0]   op_count_q;
	logic [InsnCntW-1:0] insn_count_q;
	logic                block_open_q;

	// Result register and the pending exit op that follows a limit close.
	res_t out_q;
	logic out_valid_q;
	logic exit_pend_q;

	res_t                dec_res;
	logic                dec_ok;
	logic [OpCntW-1:0]   op_count_nx;
	logic [InsnCntW-1:0] insn_count_nx;
	logic                at_limit;
	logic                slot_free;
	logic                s1_fire;
	logic                step_insn;
	res_t                step_res;
	logic                step_has_res;
	logic                step_need_exit;

	tbd_decode u_decode (
		.insn      (insn_s1),
		.pc        (cursor_q),
		.res       (dec_res),
		.supported (dec_ok)
	);

	// The result register can take a new result when it is empty or being drained.
	// While an exit op is pending, the decode stage waits so ordering is kept.
	assign slot_free   = !out_valid_q || ops.ready;
	assign s1_fire     = s1_valid && slot_free && !exit_pend_q;
	assign fetch.ready = !s1_valid || s1_fire;

	// A halfword only does work while a block is open.
	assign step_insn     = (kind_s1 == KindInsn) && block_open_q;
	assign op_count_nx   = op_count_q + OpCntW'(1);
	assign insn_count_nx = insn_count_q + InsnCntW'(1);
	assign at_limit      = (insn_count_nx >= InsnLimit) || (op_count_nx >= OpLimit);

	// Work out the result of the item in the decode stage.
	always_comb begin
		step_res       = dec_res;
		step_has_res   = step_insn;
		step_need_exit = 1'b0;
		if (!dec_ok) begin
			// Unsupported halfword closes the block; empty if nothing was decoded.
			step_res = exit_res(insn_count_q == '0);
		end else if (dec_res.op_kind == OP_BRANCH) begin
			step_res.last = 1'b1;
		end else begin
			step_need_exit = at_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (fetch.ready) begin
			s1_valid <= fetch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fetch.ready && fetch.valid) begin
			kind_s1          <= fetch.kind;
			start_address_s1 <= fetch.start_address;
			insn_s1          <= fetch.insn;
		end
	end

	// Block state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q     <= '0;
			op_count_q   <= '0;
			insn_count_q <= '0;
			block_open_q <= 1'b0;
		end else if (s1_fire) begin
			if (kind_s1 == KindStart) begin
				// A start drops any open block silently.
				cursor_q     <= start_address_s1 & 32'hFFFF_FFFE;
				op_count_q   <= '0;
				insn_count_q <= '0;
				block_open_q <= 1'b1;
			end else if (block_open_q) begin
				if (!dec_ok) begin
					block_open_q <= 1'b0;
				end else begin
					cursor_q     <= cursor_q + 32'd2;
					op_count_q   <= op_count_nx;
					insn_count_q <= insn_count_nx;
					if (dec_res.op_kind == OP_BRANCH || at_limit) begin
						block_open_q <= 1'b0;
					end
				end
			end
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			exit_pend_q <= 1'b0;
		end else if (exit_pend_q && slot_free) begin
			out_valid_q <= 1'b1;
			exit_pend_q <= 1'b0;
		end else if (s1_fire && step_has_res) begin
			out_valid_q <= 1'b1;
			exit_pend_q <= step_need_exit;
		end else if (ops.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; the exit op after a limit close carries no empty mark.
	always_ff @(posedge clk) begin
		if (exit_pend_q && slot_free) begin
			out_q <= exit_res(1'b0);
		end else if (s1_fire && step_has_res) begin
			out_q <= step_res;
		end
	end

	assign ops.valid          = out_valid_q;
	assign ops.op_kind        = out_q.op_kind;
	assign ops.dest_reg       = out_q.dest_reg;
	assign ops.first_src_reg  = out_q.first_src_reg;
	assign ops.second_src_reg = out_q.second_src_reg;
	assign ops.op_variant     = out_q.op_variant;
	assign ops.immediate      = out_q.immediate;
	assign ops.block_empty    = out_q.block_empty;
	assign ops.last           = out_q.last;

	// A pending exit op always sits behind a result that is on the output.
	a_pend_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		exit_pend_q |-> out_valid_q)
		else $error("exit op pending without a result on the output");

	// The block is already closed when its exit op is pending.
	a_pend_closed: assert property (@(posedge clk) disable iff (!arst_n)
		exit_pend_q |-> !block_open_q)
		else $error("exit op pending while the block is still open");

	// An open block never sits at or beyond its limits.
	a_open_limits: assert property (@(posedge clk) disable iff (!arst_n)
		block_open_q |-> (insn_count_q < InsnLimit) && (op_count_q < OpLimit))
		else $error("open block has reached a limit");

	// A limit close puts the op out with last clear, followed by the exit op.
	a_limit_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(exit_pend_q) |-> !out_q.last && out_q.op_kind != OP_EXIT)
		else $error("limit close did not emit a plain op before the exit");

endmodule
`default_nettype wire
